FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

FILE: rtl/core/ecu_pkg.sv
// ---------------------------------------------------------------------------
// ecu_pkg
// Constants, curve codes and the exponent table generator for the easing
// curve unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ecu_pkg;

   // Fixed-point format of progress and result: unsigned Q1.15
   localparam int FRAC_BITS = 15;
   localparam int T_W       = 16;
   localparam logic [T_W-1:0] ONE_Q  = T_W'(1) << FRAC_BITS;
   localparam logic [T_W-1:0] HALF_Q = ONE_Q >> 1;

   // Exponent argument: integer part 0..10 above the fraction
   localparam int P_W = FRAC_BITS + 5;
   localparam int IP_W = P_W - FRAC_BITS;
   localparam logic [IP_W-1:0] EXP_SPAN = IP_W'(10);
   localparam int SH_W = 4;

   // Exponent table entries: 2^(k/2^TABLE_BITS) in Q.15, just under 2.0
   localparam int ROM_W = 17;
   localparam int TABLE_BITS_DEF = 8;

   typedef enum logic [3:0] {
      CURVE_LINEAR      = 4'd0,
      CURVE_QUAD_IN     = 4'd1,
      CURVE_QUAD_OUT    = 4'd2,
      CURVE_QUAD_INOUT  = 4'd3,
      CURVE_CUBIC_IN    = 4'd4,
      CURVE_CUBIC_OUT   = 4'd5,
      CURVE_CUBIC_INOUT = 4'd6,
      CURVE_EXPO_IN     = 4'd7,
      CURVE_EXPO_OUT    = 4'd8,
      CURVE_EXPO_INOUT  = 4'd9
   } curve_type;

   // Integer square root, elaboration use only
   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_arg;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Table entry k: product of successive square roots of two, 31-bit fraction,
   // rounded to nearest at FRAC_BITS fraction bits at the end
   function automatic logic [ROM_W-1:0] exp_rom_entry(input int k, input int tb);
      logic [127:0] acc;
      logic [127:0] root;
      logic [127:0] prod;
      acc  = 128'd1 << 31;
      root = 128'd1 << 32;
      for (int j = 1; j <= tb; j++) begin
         root = 128'(isqrt64(64'(root << 31)));
         if (((k >> (tb - j)) & 1) != 0) begin
            acc = ((acc * root) + (128'd1 << 30)) >> 31;
         end
      end
      prod = ((acc * (128'd1 << FRAC_BITS)) + (128'd1 << 30)) >> 31;
      return ROM_W'(prod);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ecu_if.sv
// ---------------------------------------------------------------------------
// ecu_req_if / ecu_rsp_if
// Valid/ready channels for progress requests and eased results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ecu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [15:0] t_in;

   modport source (output valid, output req_type, output t_in, input ready);
   modport sink   (input valid, input req_type, input t_in, output ready);
endinterface

interface ecu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] eased_value;

   modport source (output valid, output eased_value, input ready);
   modport sink   (input valid, input eased_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/easing_curve_unit.sv
// ---------------------------------------------------------------------------
// easing_curve_unit
// Penner easing curves (linear, quad, cubic, expo) on Q1.15 progress values.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one beat per sample: req_type selects the curve and t_in
//   is the progress in Q1.15 (values above 1.0 count as 1.0). rsp_if returns
//   one beat, eased_value in Q1.15, for every request beat, in order.
//   Each sample passes through four register stages in order (operand
//   prepare, square and table read, cube and shift, combine); each stage
//   holds one sample and has one multiplier at most. Throughput is one
//   beat per cycle while rsp_if takes results.
//   When rsp_if stalls, the output holds and the stages behind it fill up;
//   empty stages still take new beats, and req_if.ready drops only once
//   every stage holds a sample. Nothing is lost or repeated.
//   Synchronous reset clears all stage valid bits; no table clearing is
//   needed, the exponent table is constant.
//   Unused curve codes return zero.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module easing_curve_unit
   import ecu_pkg::*;
#(
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ecu_req_if.sink    req_if,
   ecu_rsp_if.source  rsp_if
);

   // Stage enables, one per register stage
   logic en1, en2, en3, en_out;

   // Stage 1: clamped progress, multiplier operand, exponent argument
   logic                 s1_v_ff;
   logic [3:0]           s1_sel_ff;
   logic [T_W-1:0]       s1_t_ff;
   logic [T_W-1:0]       s1_a_ff;
   logic [P_W-1:0]       s1_p_ff;
   logic [T_W-1:0]       s1_t_in;
   logic [T_W-1:0]       s1_a_in;
   logic [P_W-1:0]       s1_p_in;

   // Stage 2: square, exponent shift, table read
   logic                 s2_v_ff;
   logic [3:0]           s2_sel_ff;
   logic [T_W-1:0]       s2_t_ff;
   logic [T_W-1:0]       s2_a_ff;
   logic [T_W-1:0]       s2_sq_ff;
   logic [SH_W-1:0]      s2_sh_ff;
   logic [T_W-1:0]       s2_sq_in;
   logic [SH_W-1:0]      s2_sh_in;
   logic [ROM_W-1:0]     s2_rom_data;

   // Stage 3: cube and scaled power of two
   logic                 s3_v_ff;
   logic [3:0]           s3_sel_ff;
   logic [T_W-1:0]       s3_t_ff;
   logic [T_W-1:0]       s3_sq_ff;
   logic [T_W-1:0]       s3_cube_ff;
   logic [ROM_W-1:0]     s3_e_ff;
   logic [T_W-1:0]       s3_cube_in;
   logic [ROM_W-1:0]     s3_e_in;

   // Output register
   logic                 out_v_ff;
   logic [T_W-1:0]       out_value_ff;
   logic [T_W-1:0]       out_value_in;

   // Advance a stage when it is empty or the one ahead moves
   assign en_out = !out_v_ff || rsp_if.ready;
   assign en3    = !s3_v_ff  || en_out;
   assign en2    = !s2_v_ff  || en3;
   assign en1    = !s1_v_ff  || en2;

   assign req_if.ready = en1;

   // Stage 1 logic: clamp, pick t or 1-t, scale by ten or twenty
   always_comb begin
      logic [T_W-1:0] u;
      logic           lower;
      logic           use_t;
      logic [P_W-1:0] p10;
      s1_t_in = (req_if.t_in > ONE_Q) ? ONE_Q : req_if.t_in;
      u       = ONE_Q - s1_t_in;
      lower   = s1_t_in < HALF_Q;
      case (req_if.req_type)
         CURVE_QUAD_IN, CURVE_CUBIC_IN, CURVE_EXPO_IN: use_t = 1'b1;
         CURVE_QUAD_INOUT, CURVE_CUBIC_INOUT, CURVE_EXPO_INOUT: use_t = lower;
         default: use_t = 1'b0;
      endcase
      s1_a_in = use_t ? s1_t_in : u;
      p10     = (P_W'(s1_a_in) << 3) + (P_W'(s1_a_in) << 1);
      s1_p_in = (req_if.req_type == CURVE_EXPO_INOUT) ? (p10 << 1) : p10;
   end

   // Stage 2 logic: square the operand, split the exponent argument
   always_comb begin
      logic [2*T_W-1:0] prod;
      logic [IP_W-1:0]  ip;
      prod     = {{T_W{1'b0}}, s1_a_ff} * {{T_W{1'b0}}, s1_a_ff};
      s2_sq_in = prod[FRAC_BITS +: T_W];
      ip       = s1_p_ff[P_W-1:FRAC_BITS];
      s2_sh_in = (ip > EXP_SPAN) ? '0 : SH_W'(EXP_SPAN - ip);
   end

   ecu_exp_rom #(
      .TABLE_BITS (TABLE_BITS)
   ) u_exp_rom (
      .clock   (clock),
      .rd_en   (en2),
      .rd_addr (s1_p_ff[FRAC_BITS-1 -: TABLE_BITS]),
      .rd_data (s2_rom_data)
   );

   // Stage 3 logic: cube, apply the integer part as a right shift
   always_comb begin
      logic [2*T_W-1:0] prod;
      prod       = {{T_W{1'b0}}, s2_sq_ff} * {{T_W{1'b0}}, s2_a_ff};
      s3_cube_in = prod[FRAC_BITS +: T_W];
      s3_e_in    = s2_rom_data >> s2_sh_ff;
   end

   // Output logic: fold the half-curves and endpoints together
   always_comb begin
      logic [T_W:0] one_w;
      logic [T_W:0] sq_w;
      logic [T_W:0] cube_w;
      logic [T_W:0] e_w;
      logic [T_W:0] t_w;
      logic [T_W:0] r;
      logic         lower;
      logic         t_zero;
      logic         t_one;
      one_w  = {1'b0, ONE_Q};
      sq_w   = {1'b0, s3_sq_ff};
      cube_w = {1'b0, s3_cube_ff};
      e_w    = (T_W+1)'(s3_e_ff);
      t_w    = {1'b0, s3_t_ff};
      lower  = s3_t_ff < HALF_Q;
      t_zero = s3_t_ff == '0;
      t_one  = s3_t_ff == ONE_Q;
      case (s3_sel_ff)
         CURVE_LINEAR:      r = t_w;
         CURVE_QUAD_IN:     r = sq_w;
         CURVE_QUAD_OUT:    r = one_w - sq_w;
         CURVE_QUAD_INOUT:  r = lower ? (sq_w << 1) : (one_w - (sq_w << 1));
         CURVE_CUBIC_IN:    r = cube_w;
         CURVE_CUBIC_OUT:   r = one_w - cube_w;
         CURVE_CUBIC_INOUT: r = lower ? (cube_w << 2) : (one_w - (cube_w << 2));
         CURVE_EXPO_IN:     r = t_zero ? '0 : e_w;
         CURVE_EXPO_OUT:    r = t_one ? one_w : (one_w - e_w);
         CURVE_EXPO_INOUT: begin
            if (t_zero) begin
               r = '0;
            end else if (t_one) begin
               r = one_w;
            end else if (lower) begin
               r = e_w >> 1;
            end else begin
               r = one_w - (e_w >> 1);
            end
         end
         default:           r = '0;
      endcase
      out_value_in = r[T_W-1:0];
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1)    s1_v_ff  <= req_if.valid;
         if (en2)    s2_v_ff  <= s1_v_ff;
         if (en3)    s3_v_ff  <= s2_v_ff;
         if (en_out) out_v_ff <= s3_v_ff;
      end
   end

   // Payload registers, held while the stage is stalled
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sel_ff <= req_if.req_type;
         s1_t_ff   <= s1_t_in;
         s1_a_ff   <= s1_a_in;
         s1_p_ff   <= s1_p_in;
      end
      if (en2) begin
         s2_sel_ff <= s1_sel_ff;
         s2_t_ff   <= s1_t_ff;
         s2_a_ff   <= s1_a_ff;
         s2_sq_ff  <= s2_sq_in;
         s2_sh_ff  <= s2_sh_in;
      end
      if (en3) begin
         s3_sel_ff  <= s2_sel_ff;
         s3_t_ff    <= s2_t_ff;
         s3_sq_ff   <= s2_sq_ff;
         s3_cube_ff <= s3_cube_in;
         s3_e_ff    <= s3_e_in;
      end
      if (en_out) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_if.valid       = out_v_ff;
   assign rsp_if.eased_value = out_value_ff;

   // Checks
   `ASSERT_IMPL(a_rsp_in_range, clock, reset, out_v_ff, out_value_ff <= ONE_Q)
   `ASSERT_IMPL(a_ready_low_full, clock, reset, !en1, s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff && !rsp_if.ready)
   `ASSERT_NEXT(a_s3_holds, clock, reset, s3_v_ff && !en_out, s3_v_ff && $stable(s3_t_ff) && $stable(s3_sel_ff))

endmodule

`default_nettype wire

FILE: rtl/core/ecu_exp_rom.sv
// ---------------------------------------------------------------------------
// ecu_exp_rom
// Fractional power-of-two table, 2^TABLE_BITS entries, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module ecu_exp_rom
   import ecu_pkg::*;
#(
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [TABLE_BITS-1:0] rd_addr,
   output logic      [ROM_W-1:0]      rd_data
);

   localparam int DEPTH = 1 << TABLE_BITS;

   logic [ROM_W-1:0] rom_tab [DEPTH];
   logic [ROM_W-1:0] data_ff;

   // Fill the table with constants worked out at elaboration
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
      localparam logic [ROM_W-1:0] ENTRY = exp_rom_entry(gi, TABLE_BITS);
      assign rom_tab[gi] = ENTRY;
   end

   // Registered read, hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom_tab[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

`default_nettype wire
